// ===== rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define NC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define NC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/nc_pkg.sv =====
`default_nettype none
package nc_pkg;

   // request codes
   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // top byte that marks a multicast address
   localparam logic [7:0] MCAST_TOP    = 8'hff;
   // first two bytes of a derived multicast mac
   localparam logic [7:0] MCAST_PREFIX = 8'h33;

   typedef enum logic [1:0] {
      ADD_SEARCH   = 2'd0,
      ADD_UPDATED  = 2'd1,
      ADD_INSERTED = 2'd2,
      ADD_REJECTED = 2'd3
   } add_status_type;

   typedef struct packed {
      logic        req_type;
      logic [63:0] ip_high;
      logic [63:0] ip_low;
      logic [47:0] eth_in;
   } nc_req_type;

   typedef struct packed {
      logic           found;
      logic [47:0]    eth_out;
      add_status_type add_status;
   } nc_rsp_type;

   typedef struct packed {
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [47:0] mac;
   } nc_entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_RESP
   } nc_state_type;

endpackage
`default_nettype wire

// ===== rtl/nc_match.sv =====
`default_nettype none
`include "assert_macros.svh"
module nc_match
   import nc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
   input  wire logic [63:0]                      key_high,
   input  wire logic [63:0]                      key_low,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
   input  wire nc_entry_type                     wr_entry,
   output logic                                  cmp_vld,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      cmp_idx,
   output logic                                  hit,
   output logic [47:0]                           cmp_mac
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   nc_entry_type               entry_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]   valid_ff;
   nc_entry_type               rd_data_ff;
   logic                       ent_vld_ff;
   logic                       cmp_vld_ff;
   logic [IDX_W-1:0]           cmp_idx_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
   end

   // per-entry valid bits, an invalid entry never reports a hit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // single registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_idx];
         ent_vld_ff <= valid_ff[rd_idx];
         cmp_idx_ff <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_en;
      end
   end

   // the one shared 128-bit comparator
   assign hit     = cmp_vld_ff && ent_vld_ff &&
                    (rd_data_ff.addr_high == key_high) &&
                    (rd_data_ff.addr_low == key_low);
   assign cmp_vld = cmp_vld_ff;
   assign cmp_idx = cmp_idx_ff;
   assign cmp_mac = rd_data_ff.mac;

   `NC_ASSERT_NEXT(a_read_lands, clock, reset, rd_en, cmp_vld && (cmp_idx == $past(rd_idx)))
   `NC_ASSERT_NOW(a_hit_needs_read, clock, reset, hit, cmp_vld_ff && ent_vld_ff)
   `NC_ASSERT_NEXT(a_write_sets_valid, clock, reset, wr_en, valid_ff != '0)

endmodule
`default_nettype wire

// ===== rtl/ipv6_neighbor_cache.sv =====
// IPv6 neighbor cache: a fully associative table of TABLE_ENTRIES entries mapping
// an IPv6 address to a 48-bit mac, with round-robin replacement. An add beat
// refreshes the mac of a held address or overwrites the entry at the victim pointer;
// multicast and all-zero addresses are rejected. A search beat derives 33:33 plus
// the low 32 address bits for a multicast address and otherwise looks the address
// up. Every request beat gives exactly one response beat. One request is handled at
// a time: a rejected add, a multicast search or an all-zero search goes from the
// check step straight to the response step; any other request scans the table one
// entry per cycle through the single read port of the entry memory and the one
// 128-bit comparator, stopping at the first match. A new request is accepted as soon
// as the previous one has been placed in the response register, even if that
// response is still waiting for rsp_ready. Reset clears the valid bits at once, so
// there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module ipv6_neighbor_cache
   import nc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire nc_req_type req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output nc_rsp_type      rsp_data
);

   localparam int               IDX_W    = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   nc_state_type     state_ff, state_in;
   nc_req_type       req_ff;
   nc_rsp_type       res_ff, res_in;
   nc_rsp_type       rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_stop_ff, rd_stop_in;

   // request classification on the held beat
   logic             is_mcast;
   logic             is_zero;
   logic             scan_go;
   logic             rsp_load;

   // match unit hookup
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   nc_entry_type     wr_entry;
   logic             cmp_vld;
   logic [IDX_W-1:0] cmp_idx;
   logic             hit;
   logic [47:0]      cmp_mac;
   logic             scan_end;
   logic             insert_done;

   assign is_mcast = (req_ff.ip_high[63:56] == MCAST_TOP);
   assign is_zero  = (req_ff.ip_high == 64'd0) && (req_ff.ip_low == 64'd0);
   assign scan_go  = !(is_mcast || is_zero);
   // response register is free when empty or being drained this cycle
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   // scan ends at the first match or after the last entry was compared
   assign scan_end = cmp_vld && (hit || (cmp_idx == LAST_IDX));
   // add that missed every entry and takes the victim slot
   assign insert_done = (state_ff == S_SCAN) && scan_end && !hit &&
                        (req_ff.req_type == REQ_ADD);

   nc_match #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_match (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx_ff),
      .key_high (req_ff.ip_high),
      .key_low  (req_ff.ip_low),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .cmp_vld  (cmp_vld),
      .cmp_idx  (cmp_idx),
      .hit      (hit),
      .cmp_mac  (cmp_mac)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = scan_go ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = victim_ff;
      wr_entry   = '{addr_high: req_ff.ip_high, addr_low: req_ff.ip_low,
                     mac: req_ff.eth_in};
      res_in     = res_ff;
      victim_in  = victim_ff;
      rd_idx_in  = rd_idx_ff;
      rd_stop_in = rd_stop_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_CHECK: begin
            // preset the answer for a miss, a reject or a derived multicast mac
            rd_idx_in         = '0;
            rd_stop_in        = 1'b0;
            res_in            = '0;
            res_in.add_status = (req_ff.req_type == REQ_SEARCH) ? ADD_SEARCH
                                                                : ADD_REJECTED;
            if ((req_ff.req_type == REQ_SEARCH) && is_mcast) begin
               res_in.found   = 1'b1;
               res_in.eth_out = {MCAST_PREFIX, MCAST_PREFIX, req_ff.ip_low[31:0]};
            end
         end
         S_SCAN: begin
            rd_en = !rd_stop_ff;
            if (!rd_stop_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  rd_stop_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
            if (cmp_vld && hit) begin
               if (req_ff.req_type == REQ_ADD) begin
                  // refresh the mac of the held address
                  wr_en             = 1'b1;
                  wr_idx            = cmp_idx;
                  res_in.add_status = ADD_UPDATED;
               end else begin
                  res_in.found   = 1'b1;
                  res_in.eth_out = cmp_mac;
               end
            end else if (cmp_vld && (cmp_idx == LAST_IDX)) begin
               if (req_ff.req_type == REQ_ADD) begin
                  // miss: overwrite the victim and move the pointer on
                  wr_en             = 1'b1;
                  wr_idx            = victim_ff;
                  victim_in         = (victim_ff == LAST_IDX) ? '0 : victim_ff + 1'b1;
                  res_in.add_status = ADD_INSERTED;
               end
            end
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // response register drains independently of the sequencer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         victim_ff    <= '0;
         rd_idx_ff    <= '0;
         rd_stop_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         victim_ff    <= victim_in;
         rd_idx_ff    <= rd_idx_in;
         rd_stop_ff   <= rd_stop_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a match always ends the scan and moves to the response step
   `NC_ASSERT_NEXT(a_hit_ends_scan, clock, reset, (state_ff == S_SCAN) && hit, state_ff == S_RESP)
   // the victim pointer moves only when a new entry is inserted
   `NC_ASSERT_NEXT(a_victim_moves_on_insert, clock, reset, !insert_done, $stable(victim_ff))
   // a response is only loaded out of the response step
   `NC_ASSERT_NOW(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_RESP)
   // the table is written only while scanning
   `NC_ASSERT_NOW(a_write_in_scan, clock, reset, wr_en, state_ff == S_SCAN)

endmodule
`default_nettype wire

// ===== test/ipv6_neighbor_cache_test.sv =====
`default_nettype none
module ipv6_neighbor_cache_test;
   import nc_pkg::*;

   localparam int ENTRIES    = 16;
   // address pool a bit larger than the table so replacement kicks in
   localparam int POOL       = 24;
   localparam int RANDOM_OPS = 800;
   // worst case is a full scan per beat plus rare gaps; this is many times that
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   nc_req_type req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   nc_rsp_type rsp_data;

   // shadow copy of the neighbor table
   logic [63:0] shadow_high [ENTRIES];
   logic [63:0] shadow_low  [ENTRIES];
   logic [47:0] shadow_mac  [ENTRIES];
   int          shadow_victim;

   // answers owed by the cache, oldest first
   nc_rsp_type  awaited_answers[$];

   // frequently used unicast addresses, so searches and updates actually hit
   logic [63:0] pool_high [POOL];
   logic [63:0] pool_low  [POOL];

   // set during the stretch where neither side inserts gaps
   bit quiet = 1'b0;
   int fail_count = 0;
   int cycle_count = 0;

   ipv6_neighbor_cache #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ipv6_neighbor_cache verification failed");
         $finish;
      end
   end

   // response side back-pressure, about one cycle in ten stalled
   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 10);
   end

   // what the cache must answer for one request, updating the shadow table
   function automatic nc_rsp_type answer_for(input nc_req_type r);
      nc_rsp_type ans;
      int         hit;
      logic       mcast;
      logic       zero;
      ans.found      = 1'b0;
      ans.eth_out    = '0;
      ans.add_status = ADD_SEARCH;
      mcast = (r.ip_high[63:56] == MCAST_TOP);
      zero  = (r.ip_high == '0) && (r.ip_low == '0);
      // lowest matching index wins
      hit = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (shadow_high[i] == r.ip_high && shadow_low[i] == r.ip_low) hit = i;
      end
      if (r.req_type == REQ_ADD) begin
         if (mcast || zero) begin
            ans.add_status = ADD_REJECTED;
         end else if (hit >= 0) begin
            shadow_mac[hit] = r.eth_in;
            ans.add_status  = ADD_UPDATED;
         end else begin
            // round-robin overwrite of the victim entry
            shadow_high[shadow_victim] = r.ip_high;
            shadow_low[shadow_victim]  = r.ip_low;
            shadow_mac[shadow_victim]  = r.eth_in;
            shadow_victim  = (shadow_victim + 1) % ENTRIES;
            ans.add_status = ADD_INSERTED;
         end
      end else if (mcast) begin
         // multicast maps to 33:33 plus low 32 address bits
         ans.found   = 1'b1;
         ans.eth_out = {MCAST_PREFIX, MCAST_PREFIX, r.ip_low[31:0]};
      end else if (!zero && hit >= 0) begin
         ans.found   = 1'b1;
         ans.eth_out = shadow_mac[hit];
      end
      return ans;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random unicast address, sometimes with one half all zero
   function automatic void make_unicast(output logic [63:0] hi, output logic [63:0] lo);
      int shape;
      shape = $urandom_range(0, 9);
      hi = rand64();
      hi[63:56] = 8'($urandom_range(0, 254));
      lo = rand64();
      if (shape == 0) begin
         hi = '0;
         if (lo == '0) lo = 64'd1;
      end else if (shape == 1) begin
         lo = '0;
         if (hi == '0) hi = 64'd1;
      end
   endfunction

   // drive one request beat; the answer is predicted when the beat is taken
   task automatic send_beat(input nc_req_type item);
      while (!quiet && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_answers.push_back(answer_for(item));
      @(negedge clock);
   endtask

   task automatic add_neighbor(input logic [63:0] hi, input logic [63:0] lo,
                               input logic [47:0] mac);
      nc_req_type item;
      item.req_type = REQ_ADD;
      item.ip_high  = hi;
      item.ip_low   = lo;
      item.eth_in   = mac;
      send_beat(item);
   endtask

   task automatic find_neighbor(input logic [63:0] hi, input logic [63:0] lo);
      nc_req_type item;
      item.req_type = REQ_SEARCH;
      item.ip_high  = hi;
      item.ip_low   = lo;
      item.eth_in   = 48'(rand64());
      send_beat(item);
   endtask

   // sender holds off until every owed answer has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_answers.size() != 0) @(negedge clock);
   endtask

   // rejected adds, all-zero search and a miss on the empty table
   task automatic test_rejects();
      add_neighbor('0, '0, 48'hffff_ffff_ffff);
      add_neighbor({MCAST_TOP, 56'd0}, '0, 48'h0000_0000_0001);
      add_neighbor('1, '1, '1);
      find_neighbor('0, '0);
      find_neighbor(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001);
      wait_drained();
   endtask

   // derived multicast mac, low address bits at both extremes
   task automatic test_multicast_search();
      find_neighbor('1, '1);
      find_neighbor({MCAST_TOP, 56'd0}, '0);
      find_neighbor({MCAST_TOP, 56'h02_0000_0000_0000}, 64'hffff_ffff_0000_0000);
      find_neighbor({MCAST_TOP, 56'h02_0000_0000_0000}, 64'h0000_0000_8000_0001);
      wait_drained();
   endtask

   // insert, hit, update in place, and addresses with one half zero
   task automatic test_add_update();
      add_neighbor(64'hfeff_ffff_ffff_ffff, '1, '1);
      find_neighbor(64'hfeff_ffff_ffff_ffff, '1);
      add_neighbor(64'hfeff_ffff_ffff_ffff, '1, '0);
      find_neighbor(64'hfeff_ffff_ffff_ffff, '1);
      add_neighbor('0, 64'd1, 48'h0a0b_0c0d_0e0f);
      add_neighbor(64'd1, '0, 48'h1234_5678_9abc);
      find_neighbor('0, 64'd1);
      find_neighbor(64'd1, '0);
      // high half matches one entry, low half another: still a miss
      find_neighbor(64'd1, 64'd1);
      add_neighbor('0, 64'd1, 48'h8000_0000_0000);
      find_neighbor('0, 64'd1);
      wait_drained();
   endtask

   // overfill the table so the oldest entries get evicted and the pointer wraps
   task automatic test_replacement();
      logic [63:0] hi_list [ENTRIES + 4];
      logic [63:0] lo_list [ENTRIES + 4];
      for (int i = 0; i < ENTRIES + 4; i++) begin
         make_unicast(hi_list[i], lo_list[i]);
         add_neighbor(hi_list[i], lo_list[i], 48'(rand64()));
      end
      for (int i = 0; i < ENTRIES + 4; i++) find_neighbor(hi_list[i], lo_list[i]);
      wait_drained();
   endtask

   // mixed adds and searches mostly over a small address pool
   task automatic test_random_traffic();
      nc_req_type item;
      int         pick;
      int         slot;
      for (int i = 0; i < POOL; i++) make_unicast(pool_high[i], pool_low[i]);
      for (int n = 0; n < RANDOM_OPS; n++) begin
         // gap-free stretch on both sides
         quiet = (n >= 300 && n < 450);
         item.req_type = ($urandom_range(0, 99) < 45) ? REQ_ADD : REQ_SEARCH;
         item.eth_in   = 48'(rand64());
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            slot = $urandom_range(0, POOL - 1);
            item.ip_high = pool_high[slot];
            item.ip_low  = pool_low[slot];
         end else if (pick < 80) begin
            item.ip_high = {MCAST_TOP, 56'(rand64())};
            item.ip_low  = rand64();
         end else if (pick < 85) begin
            item.ip_high = '0;
            item.ip_low  = '0;
         end else begin
            item.ip_high = rand64();
            item.ip_low  = rand64();
         end
         // slowly churn the pool
         if ($urandom_range(0, 99) == 0) begin
            slot = $urandom_range(0, POOL - 1);
            make_unicast(pool_high[slot], pool_low[slot]);
         end
         send_beat(item);
         if (n % 200 == 199) wait_drained();
      end
      quiet = 1'b0;
      wait_drained();
   endtask

   // compare every response beat with the oldest owed answer
   always @(posedge clock) begin : answer_check
      nc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               fail_count++;
            end
            if (rsp_data.eth_out !== want.eth_out) begin
               $error("eth_out: expected %h, got %h", want.eth_out, rsp_data.eth_out);
               fail_count++;
            end
            if (rsp_data.add_status !== want.add_status) begin
               $error("add_status: expected %0d, got %0d",
                      want.add_status, rsp_data.add_status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_high[i] = '0;
         shadow_low[i]  = '0;
         shadow_mac[i]  = '0;
      end
      shadow_victim = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_rejects();
      test_multicast_search();
      test_add_update();
      test_replacement();
      test_random_traffic();

      // let any stray beat show up: one full scan plus margin
      repeat (ENTRIES + 10) @(posedge clock);
      if (awaited_answers.size() != 0) begin
         $error("%0d answers never arrived", awaited_answers.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ipv6_neighbor_cache verification clean");
      end else begin
         $display("ipv6_neighbor_cache verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
